// ----- sv/periodic_timer_table_assert.svh -----
// Assertion macros used by the checker file ptt_checker.sv.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- sv/ptt_pkg.sv -----
package ptt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int TIME_W      = 64;
    localparam int PERIOD_W    = 32;
    localparam int SLOT_FW     = 4;
    localparam int KEEP_W      = 16;
    localparam int REQ_W       = 2;
    localparam int KIND_W      = 3;
    localparam int ERR_W       = 2;
    localparam int GATE_W      = 32;
    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 8;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [19:0]       US_PER_S    = 20'd1000000;
    localparam logic [GATE_W-1:0] GATE_RESET  = 32'd1000000;
    localparam logic [0:0]        REG_TICK_GATE = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK       = 2'd0,
        REQ_REGISTER   = 2'd1,
        REQ_UNREGISTER = 2'd2,
        REQ_NONE       = 2'd3
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REG    = 3'd0,
        KIND_FIRE   = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_ERR    = 3'd3,
        KIND_DONE   = 3'd4
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE          = 2'd0,
        ERR_ZERO_INTERVAL = 2'd1,
        ERR_TABLE_FULL    = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_REG,
        EMIT_ERR_ZERO,
        EMIT_ERR_FULL,
        EMIT_REMOVE,
        EMIT_DONE,
        EMIT_FIRE
    } emit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_PASS_DONE
    } state_t;

    typedef struct packed {
        logic  load;
        emit_t emit;
        logic  do_register;
        logic  do_unreg;
        logic  first_tick;
        logic  pass_start;
        logic  rd_issue;
        logic  mul_stage;
        logic  fire;
        logic  idx_inc;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic interval_zero;
        logic free_any;
        logic pass_seen;
        logic gate_ok;
        logic cur_busy;
        logic elapsed;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

// ----- sv/ptt_ram.sv -----
module ptt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/ptt_ctrl.sv -----
module ptt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ptt_pkg::sts_t sts,
    output ptt_pkg::cmd_t cmd
);

    ptt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ptt_pkg::ST_DECODE;
                end
            end
            ptt_pkg::ST_DECODE: begin
                if (sts.req == ptt_pkg::REQ_TICK && sts.pass_seen && sts.gate_ok) begin
                    state_next = ptt_pkg::ST_SCAN_RD;
                end else if (sts.out_free) begin
                    state_next = ptt_pkg::ST_IDLE;
                end
            end
            ptt_pkg::ST_SCAN_RD: begin
                if (sts.cur_busy) begin
                    state_next = ptt_pkg::ST_SCAN_MUL;
                end else if (sts.idx_last) begin
                    state_next = ptt_pkg::ST_PASS_DONE;
                end
            end
            ptt_pkg::ST_SCAN_MUL: begin
                state_next = ptt_pkg::ST_SCAN_CMP;
            end
            ptt_pkg::ST_SCAN_CMP: begin
                if (!sts.elapsed || sts.out_free) begin
                    state_next = sts.idx_last ? ptt_pkg::ST_PASS_DONE : ptt_pkg::ST_SCAN_RD;
                end
            end
            ptt_pkg::ST_PASS_DONE: begin
                if (sts.out_free) begin
                    state_next = ptt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.emit = ptt_pkg::EMIT_NONE;
        s_ready  = 1'b0;
        case (state_reg)
            ptt_pkg::ST_IDLE: begin
                // refuse requests while reset is held
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
            end
            ptt_pkg::ST_DECODE: begin
                case (sts.req)
                    ptt_pkg::REQ_REGISTER: begin
                        if (sts.out_free) begin
                            if (sts.interval_zero) begin
                                cmd.emit = ptt_pkg::EMIT_ERR_ZERO;
                            end else if (!sts.free_any) begin
                                cmd.emit = ptt_pkg::EMIT_ERR_FULL;
                            end else begin
                                cmd.do_register = 1'b1;
                                cmd.emit        = ptt_pkg::EMIT_REG;
                            end
                        end
                    end
                    ptt_pkg::REQ_UNREGISTER: begin
                        if (sts.out_free) begin
                            cmd.do_unreg = 1'b1;
                            cmd.emit     = ptt_pkg::EMIT_REMOVE;
                        end
                    end
                    ptt_pkg::REQ_TICK: begin
                        if (!sts.pass_seen) begin
                            if (sts.out_free) begin
                                cmd.first_tick = 1'b1;
                                cmd.emit       = ptt_pkg::EMIT_DONE;
                            end
                        end else if (!sts.gate_ok) begin
                            if (sts.out_free) begin
                                cmd.emit = ptt_pkg::EMIT_DONE;
                            end
                        end else begin
                            cmd.pass_start = 1'b1;
                        end
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.emit = ptt_pkg::EMIT_DONE;
                        end
                    end
                endcase
            end
            ptt_pkg::ST_SCAN_RD: begin
                if (sts.cur_busy) begin
                    cmd.rd_issue = 1'b1;
                end else if (!sts.idx_last) begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ptt_pkg::ST_SCAN_MUL: begin
                cmd.mul_stage = 1'b1;
            end
            ptt_pkg::ST_SCAN_CMP: begin
                if (sts.elapsed && sts.out_free) begin
                    cmd.fire = 1'b1;
                    cmd.emit = ptt_pkg::EMIT_FIRE;
                end
                if ((!sts.elapsed || sts.out_free) && !sts.idx_last) begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ptt_pkg::ST_PASS_DONE: begin
                if (sts.out_free) begin
                    cmd.emit = ptt_pkg::EMIT_DONE;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/ptt_dp.sv -----
module ptt_dp #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ptt_pkg::cmd_t                   cmd,
    output ptt_pkg::sts_t                   sts,
    input  logic [ptt_pkg::REQ_W-1:0]       in_req_type,
    input  logic [ptt_pkg::TIME_W-1:0]      in_now_us,
    input  logic [ptt_pkg::PERIOD_W-1:0]    in_interval_s,
    input  logic [ptt_pkg::SLOT_FW-1:0]     in_slot_id,
    input  logic [ptt_pkg::KEEP_W-1:0]      in_keep_mask,
    input  logic                            cfg_we,
    input  logic [ptt_pkg::GATE_W-1:0]      cfg_wdata,
    output logic [ptt_pkg::GATE_W-1:0]      cfg_gate,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [ptt_pkg::KIND_W-1:0]      out_kind,
    output logic [ptt_pkg::SLOT_FW-1:0]     out_slot,
    output logic                            out_dropped,
    output logic [ptt_pkg::ERR_W-1:0]       out_error_code,
    output logic                            out_last
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RAM_W = ptt_pkg::PERIOD_W + ptt_pkg::TIME_W;

    // captured request
    ptt_pkg::req_t                 req_reg;
    logic [ptt_pkg::TIME_W-1:0]    now_reg;
    logic [ptt_pkg::PERIOD_W-1:0]  interval_reg;
    logic [ptt_pkg::SLOT_FW-1:0]   slot_id_reg;
    logic [ptt_pkg::KEEP_W-1:0]    keep_reg;

    logic [ptt_pkg::GATE_W-1:0]    gate_reg;
    logic [ptt_pkg::TIME_W-1:0]    last_pass_reg;
    logic                          pass_seen_reg;

    logic [SLOTS-1:0]              busy_reg, busy_next;
    logic [SW-1:0]                 free_hi_reg, free_hi_next;
    logic                          free_any_reg, free_any_next;
    logic [SW-1:0]                 idx_reg;

    logic [ptt_pkg::TIME_W-1:0]    prod_reg;
    logic [ptt_pkg::TIME_W-1:0]    diff_reg;

    logic                          ram_we;
    logic [SW-1:0]                 ram_waddr;
    logic [RAM_W-1:0]              ram_wdata;
    logic [RAM_W-1:0]              ram_rdata;
    logic [ptt_pkg::PERIOD_W-1:0]  rd_period;
    logic [ptt_pkg::TIME_W-1:0]    rd_start;

    logic [SLOTS-1:0]              keep_vec;
    logic                          kept_cur;
    logic                          gate_ok;

    logic                          out_valid_reg;
    ptt_pkg::kind_t                out_kind_reg, out_kind_next;
    logic [ptt_pkg::SLOT_FW-1:0]   out_slot_reg, out_slot_next;
    logic                          out_dropped_reg, out_dropped_next;
    ptt_pkg::err_t                 out_err_reg, out_err_next;
    logic                          out_last_reg, out_last_next;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg      <= ptt_pkg::req_t'(in_req_type);
            now_reg      <= in_now_us;
            interval_reg <= in_interval_s;
            slot_id_reg  <= in_slot_id;
            keep_reg     <= in_keep_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg <= ptt_pkg::GATE_RESET;
        end else if (cfg_we) begin
            gate_reg <= cfg_wdata;
        end
    end

    assign cfg_gate = gate_reg;

    // wrapping difference against the gate
    assign gate_ok = (now_reg - last_pass_reg) >= {32'd0, gate_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pass_reg <= '0;
            pass_seen_reg <= 1'b0;
        end else if (cmd.first_tick || cmd.pass_start) begin
            last_pass_reg <= now_reg;
            pass_seen_reg <= 1'b1;
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_keep
        if (g < ptt_pkg::KEEP_W) begin : g_in
            assign keep_vec[g] = keep_reg[g];
        end else begin : g_out
            assign keep_vec[g] = 1'b0;
        end
    end

    assign kept_cur = keep_vec[idx_reg];

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            busy_next[i] = busy_reg[i];
            if (cmd.do_register && free_hi_reg == SW'(i)) begin
                busy_next[i] = 1'b1;
            end
            if (cmd.do_unreg && 32'(slot_id_reg) == i) begin
                busy_next[i] = 1'b0;
            end
            if (cmd.fire && !kept_cur && idx_reg == SW'(i)) begin
                busy_next[i] = 1'b0;
            end
        end
    end

    // highest free slot, registered from the busy bits of the previous cycle
    always_comb begin
        free_hi_next  = '0;
        free_any_next = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!busy_reg[i]) begin
                free_hi_next  = SW'(i);
                free_any_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= '0;
            free_hi_reg  <= SW'(SLOTS - 1);
            free_any_reg <= 1'b1;
        end else begin
            busy_reg     <= busy_next;
            free_hi_reg  <= free_hi_next;
            free_any_reg <= free_any_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.pass_start) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + SW'(1);
        end
    end

    assign ram_we    = cmd.do_register || (cmd.fire && kept_cur);
    assign ram_waddr = cmd.do_register ? free_hi_reg : idx_reg;
    assign ram_wdata = cmd.do_register ? {interval_reg, now_reg} : {rd_period, now_reg};

    ptt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_period = ram_rdata[RAM_W-1:ptt_pkg::TIME_W];
    assign rd_start  = ram_rdata[ptt_pkg::TIME_W-1:0];

    // widen both operands so the product keeps all of its bits
    always_ff @(posedge aclk) begin
        if (cmd.mul_stage) begin
            prod_reg <= ptt_pkg::TIME_W'(rd_period) * ptt_pkg::TIME_W'(ptt_pkg::US_PER_S);
            diff_reg <= now_reg - rd_start;
        end
    end

    always_comb begin
        out_kind_next    = ptt_pkg::KIND_DONE;
        out_slot_next    = '0;
        out_dropped_next = 1'b0;
        out_err_next     = ptt_pkg::ERR_NONE;
        out_last_next    = 1'b1;
        case (cmd.emit)
            ptt_pkg::EMIT_REG: begin
                out_kind_next = ptt_pkg::KIND_REG;
                out_slot_next = ptt_pkg::SLOT_FW'(free_hi_reg);
            end
            ptt_pkg::EMIT_ERR_ZERO: begin
                out_kind_next = ptt_pkg::KIND_ERR;
                out_err_next  = ptt_pkg::ERR_ZERO_INTERVAL;
            end
            ptt_pkg::EMIT_ERR_FULL: begin
                out_kind_next = ptt_pkg::KIND_ERR;
                out_err_next  = ptt_pkg::ERR_TABLE_FULL;
            end
            ptt_pkg::EMIT_REMOVE: begin
                out_kind_next = ptt_pkg::KIND_REMOVE;
                out_slot_next = slot_id_reg;
            end
            ptt_pkg::EMIT_FIRE: begin
                out_kind_next    = ptt_pkg::KIND_FIRE;
                out_slot_next    = ptt_pkg::SLOT_FW'(idx_reg);
                out_dropped_next = !kept_cur;
                out_last_next    = 1'b0;
            end
            default: begin
                out_kind_next = ptt_pkg::KIND_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit != ptt_pkg::EMIT_NONE) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit != ptt_pkg::EMIT_NONE) begin
            out_kind_reg    <= out_kind_next;
            out_slot_reg    <= out_slot_next;
            out_dropped_reg <= out_dropped_next;
            out_err_reg     <= out_err_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_slot       = out_slot_reg;
    assign out_dropped    = out_dropped_reg;
    assign out_error_code = out_err_reg;
    assign out_last       = out_last_reg;

    always_comb begin
        sts               = '0;
        sts.req           = req_reg;
        sts.interval_zero = (interval_reg == '0);
        sts.free_any      = free_any_reg;
        sts.pass_seen     = pass_seen_reg;
        sts.gate_ok       = gate_ok;
        sts.cur_busy      = busy_reg[idx_reg];
        sts.elapsed       = (prod_reg <= diff_reg);
        sts.idx_last      = (idx_reg == SW'(SLOTS - 1));
        sts.out_free      = !out_valid_reg || out_ready;
    end

endmodule

// ----- sv/periodic_timer_table.sv -----
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   request: tuser req_type, tdata time/interval/slot/keep
// m_*       out  m_tvalid/m_tready   result: tuser kind, tdata slot/dropped/error, tlast
// APB       in   psel/penable        tick_gate_us at byte address 0, pready tied high
//
// Register, unregister and unknown requests: one result each, emitted from the decode state.
// Tick pass: the scan walks one slot per cycle over idle slots; a busy slot also goes through
// ST_SCAN_MUL for the table read and period multiply, and ST_SCAN_CMP waits on a stalled m_*.
// Reset (aresetn low, synchronous) empties the table at once: busy flags clear, no sweep.
// m_tready low holds the sequencer on the pending result; one request at a time.
module periodic_timer_table #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [63:0] now_us, [95:64] interval_s, [99:96] slot_id, [115:100] keep_mask, [119:116] zero
    input  logic [ptt_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  logic [ptt_pkg::REQ_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] slot, [4] dropped, [6:5] error_code, [7] zero
    output logic [ptt_pkg::M_TDATA_W-1:0]    m_tdata,
    // [2:0] kind
    output logic [ptt_pkg::KIND_W-1:0]       m_tuser,
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ptt_pkg::PADDR_W-1:0]      paddr,
    input  logic [ptt_pkg::PDATA_W-1:0]      pwdata,
    output logic [ptt_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    ptt_pkg::cmd_t                   cmd;
    ptt_pkg::sts_t                   sts;
    logic                            cfg_hit;
    logic                            cfg_we;
    logic [ptt_pkg::GATE_W-1:0]      cfg_gate;
    logic [ptt_pkg::SLOT_FW-1:0]     out_slot;
    logic                            out_dropped;
    logic [ptt_pkg::ERR_W-1:0]       out_error_code;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[ptt_pkg::PADDR_W-1:2] == ptt_pkg::REG_TICK_GATE);
    assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? cfg_gate : '0;

    ptt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_req_type    (s_tuser),
        .in_now_us      (s_tdata[63:0]),
        .in_interval_s  (s_tdata[95:64]),
        .in_slot_id     (s_tdata[99:96]),
        .in_keep_mask   (s_tdata[115:100]),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata),
        .cfg_gate       (cfg_gate),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_kind       (m_tuser),
        .out_slot       (out_slot),
        .out_dropped    (out_dropped),
        .out_error_code (out_error_code),
        .out_last       (m_tlast)
    );

    assign m_tdata = {1'b0, out_error_code, out_dropped, out_slot};

endmodule

// ----- sv/ptt_checker.sv -----
`include "periodic_timer_table_assert.svh"

module ptt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ptt_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [ptt_pkg::KIND_W-1:0]       m_tuser,
    input logic                             m_tlast
);

    // a stalled result holds
    `PTT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // one request at a time: no acceptance right after another
    `PTT_ASSERT_NEXT(a_one_req, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // only fired results leave a transaction open
    `PTT_ASSERT_IMPL(a_last_rule, aclk, aresetn, m_tvalid,
        (m_tuser == ptt_pkg::KIND_FIRE) != m_tlast)

    // errors carry a code and no slot; other results carry no code
    `PTT_ASSERT_IMPL(a_err_code, aclk, aresetn, m_tvalid,
        (m_tuser == ptt_pkg::KIND_ERR) ? (m_tdata[6:5] != 2'd0 && m_tdata[3:0] == 4'd0)
                                       : (m_tdata[6:5] == 2'd0))

endmodule

bind periodic_timer_table ptt_checker u_checker (.*);
